>>> hdl/prsu_pkg.sv
// Package for the register and scroll unit of the tile video unit.
// Holds the transfer payload types, port codes and the nametable mirroring table.
// Depends on nothing; every module of the unit imports it.
`timescale 1ns / 1ps
`default_nettype none

package prsu_pkg;

	// register ports as seen from the CPU bus
	typedef enum logic [2:0] {
		PORT_CONTROL = 3'd0,
		PORT_MASK    = 3'd1,
		PORT_STATUS  = 3'd2,
		PORT_SPR_ADR = 3'd3,
		PORT_SPR_DAT = 3'd4,
		PORT_SCROLL  = 3'd5,
		PORT_ADDRESS = 3'd6,
		PORT_DATA    = 3'd7
	} port_t;

	// item kinds
	localparam logic FUNC_REG_WRITE  = 1'b0;
	localparam logic FUNC_LINE_START = 1'b1;

	// configuration register indexes
	localparam logic CFG_MIRRORING   = 1'b0;
	localparam logic CFG_VIDEO_BLOCK = 1'b1;
	localparam int   CFG_DATA_W      = 3;

	// mirroring modes
	localparam logic [2:0] MIR_HORIZONTAL  = 3'd0;
	localparam logic [2:0] MIR_VERTICAL    = 3'd1;
	localparam logic [2:0] MIR_SINGLE_LOW  = 3'd2;
	localparam logic [2:0] MIR_SINGLE_HIGH = 3'd3;
	localparam logic [2:0] MIR_FOUR_SCREEN = 3'd4;

	localparam logic [15:0] DATA_PTR_RESET  = 16'h2000;
	localparam logic [15:0] PALETTE_ALIAS   = 16'h3F10;
	localparam logic [15:0] STEP_ACROSS     = 16'h0001;
	localparam logic [15:0] STEP_DOWN       = 16'h0020;
	localparam logic [4:0]  COARSE_Y_LAST   = 5'd29;
	localparam logic [4:0]  COARSE_Y_MAX    = 5'd31;

	typedef struct packed {
		logic       func;
		logic [2:0] reg_index;
		logic [7:0] write_value;
		logic       first_line;
	} cmd_t;

	typedef struct packed {
		logic        vram_write;
		logic [15:0] vram_address;
		logic        nametable_write;
		logic [1:0]  nametable_page;
		logic [9:0]  nametable_offset;
		logic        palette_alias_write;
		logic        sprite_write;
		logic [7:0]  spr_mem_address;
		logic [7:0]  data_out;
		logic [14:0] render_address;
		logic [2:0]  fine_scroll_x;
		logic [7:0]  control_byte;
	} res_t;

	// decoded data-port address
	typedef struct packed {
		logic       nt_hit;
		logic [1:0] nt_page;
		logic [9:0] nt_offset;
		logic       pal_hit;
	} nt_map_t;

	// physical page for a logical nametable quadrant; undefined modes act as horizontal
	function automatic logic [1:0] mirror_page(input logic [2:0] mode, input logic [1:0] quad);
		logic [1:0] page;
		begin
			unique case (mode)
				MIR_VERTICAL:    page = {1'b0, quad[0]};
				MIR_SINGLE_LOW:  page = 2'd0;
				MIR_SINGLE_HIGH: page = 2'd1;
				MIR_FOUR_SCREEN: page = quad;
				default:         page = {1'b0, quad[1]};
			endcase
			return page;
		end
	endfunction

endpackage

`default_nettype wire

>>> hdl/prsu_nt_map.sv
// Nametable and palette alias decode of the data-port address.
// Depends on prsu_pkg for the mirroring table and the nt_map_t struct.
`timescale 1ns / 1ps
`default_nettype none

module prsu_nt_map
	import prsu_pkg::*;
(
	input  wire logic [15:0] addr,
	input  wire logic [2:0]  mode,
	output nt_map_t          map
);

	// 0x2000..0x3EFF; folding 0x3000 onto 0x2000 only clears bit 12
	always_comb begin
		map.nt_hit    = (addr[15:13] == 3'b001) && (addr[12:8] != 5'h1F);
		map.nt_page   = map.nt_hit ? mirror_page(mode, addr[11:10]) : 2'd0;
		map.nt_offset = map.nt_hit ? addr[9:0] : 10'd0;
		map.pal_hit   = (addr == PALETTE_ALIAS);
	end

endmodule

`default_nettype wire

>>> hdl/prsu_regfile.sv
// Register file and scroll address state: next state and result for one item.
// Depends on prsu_pkg and prsu_nt_map.
`timescale 1ns / 1ps
`default_nettype none

module prsu_regfile
	import prsu_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       take,
	input  wire cmd_t       cmd,
	input  wire logic [2:0] mirroring_mode,
	input  wire logic       video_write_block,
	output res_t            res
);

	logic [7:0]  control_q, mask_q, spr_ptr_q;
	logic        scroll_tgl_q, addr_tgl_q;
	logic [14:0] temp_q, view_q;
	logic [2:0]  fine_x_q;
	logic [15:0] data_ptr_q;

	logic [7:0]  control_d, mask_d, spr_ptr_d;
	logic        scroll_tgl_d, addr_tgl_d;
	logic [14:0] temp_d, view_d, reload, stepped;
	logic [2:0]  fine_x_d;
	logic [15:0] data_ptr_d;
	nt_map_t     map;
	logic [7:0]  d;

	prsu_nt_map u_nt_map (
		.addr (data_ptr_q),
		.mode (mirroring_mode),
		.map  (map)
	);

	assign d = cmd.write_value;

	// horizontal (or full) reload, then vertical step
	always_comb begin
		reload  = cmd.first_line ? temp_q : {view_q[14:11], temp_q[10], view_q[9:5], temp_q[4:0]};
		stepped = reload;
		if (reload[14:12] == 3'd7) begin
			stepped[14:12] = 3'd0;
			if (reload[9:5] == COARSE_Y_LAST) begin
				stepped[11]  = ~reload[11];
				stepped[9:5] = 5'd0;
			end else if (reload[9:5] == COARSE_Y_MAX) begin
				stepped[9:5] = 5'd0;
			end else begin
				stepped[9:5] = reload[9:5] + 5'd1;
			end
		end else begin
			stepped[14:12] = reload[14:12] + 3'd1;
		end
	end

	always_comb begin
		control_d    = control_q;
		mask_d       = mask_q;
		spr_ptr_d    = spr_ptr_q;
		scroll_tgl_d = scroll_tgl_q;
		addr_tgl_d   = addr_tgl_q;
		temp_d       = temp_q;
		view_d       = view_q;
		fine_x_d     = fine_x_q;
		data_ptr_d   = data_ptr_q;
		res          = '0;

		if (cmd.func == FUNC_LINE_START) begin
			view_d = stepped;
			res.render_address = reload;
		end else begin
			unique case (port_t'(cmd.reg_index))
				PORT_CONTROL: begin
					control_d      = d;
					temp_d[11:10]  = d[1:0];
				end
				PORT_MASK: begin
					mask_d = d;
				end
				PORT_SPR_ADR: begin
					spr_ptr_d = d;
				end
				PORT_SPR_DAT: begin
					res.sprite_write    = 1'b1;
					res.spr_mem_address = spr_ptr_q;
					res.data_out        = d;
					spr_ptr_d           = spr_ptr_q + 8'd1;
				end
				PORT_SCROLL: begin
					if (!scroll_tgl_q) begin
						temp_d[4:0] = d[7:3];
						fine_x_d    = d[2:0];
					end else begin
						temp_d[9:5]   = d[7:3];
						temp_d[14:12] = d[2:0];
					end
					scroll_tgl_d = ~scroll_tgl_q;
				end
				PORT_ADDRESS: begin
					if (!addr_tgl_q) begin
						temp_d[14:8] = {1'b0, d[5:0]};
					end else begin
						temp_d[7:0] = d;
						view_d      = {temp_q[14:8], d};
						data_ptr_d  = {1'b0, temp_q[14:8], d};
					end
					addr_tgl_d = ~addr_tgl_q;
				end
				PORT_DATA: begin
					if (!video_write_block) begin
						res.vram_write          = 1'b1;
						res.vram_address        = data_ptr_q;
						res.data_out            = d;
						res.nametable_write     = map.nt_hit;
						res.nametable_page      = map.nt_page;
						res.nametable_offset    = map.nt_offset;
						res.palette_alias_write = map.pal_hit;
						data_ptr_d = data_ptr_q + (control_q[2] ? STEP_DOWN : STEP_ACROSS);
					end
				end
				default: begin
				end
			endcase
			res.render_address = view_d;
		end
		res.fine_scroll_x = fine_x_d;
		res.control_byte  = control_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			control_q    <= '0;
			mask_q       <= '0;
			spr_ptr_q    <= '0;
			scroll_tgl_q <= 1'b0;
			addr_tgl_q   <= 1'b0;
			temp_q       <= '0;
			view_q       <= '0;
			fine_x_q     <= '0;
			data_ptr_q   <= DATA_PTR_RESET;
		end else if (take) begin
			control_q    <= control_d;
			mask_q       <= mask_d;
			spr_ptr_q    <= spr_ptr_d;
			scroll_tgl_q <= scroll_tgl_d;
			addr_tgl_q   <= addr_tgl_d;
			temp_q       <= temp_d;
			view_q       <= view_d;
			fine_x_q     <= fine_x_d;
			data_ptr_q   <= data_ptr_d;
		end
	end

endmodule

`default_nettype wire

>>> hdl/ppu_register_scroll_unit.sv
// Top level of the register and scroll unit: configuration registers and result stage.
// Depends on prsu_pkg, prsu_regfile and prsu_nt_map.
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+-----------------------------
//  cmd     | in        | cmd_valid / cmd_stall | cmd_t: register write or line start
//  res     | out       | res_valid / res_stall | res_t: write commands and scroll view
//  cfg     | in        | cfg_write_en          | cfg_index, cfg_data
//
// One item per cycle unless cmd_stall is high: the item is transferred at a clock edge,
// its state update and result are formed in the same cycle and the result is presented
// from the next cycle, held in the single result register.
// cmd_stall is raised only while a result waits in the register and res_stall is high;
// a transfer on res in the same cycle frees the register for the next item.
// Reset clears all state but the result payload; the data pointer comes out of reset at 0x2000.
`timescale 1ns / 1ps
`default_nettype none

module ppu_register_scroll_unit
	import prsu_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cmd_valid,
	output logic                       cmd_stall,
	input  wire cmd_t                  cmd,
	output logic                       res_valid,
	input  wire logic                  res_stall,
	output res_t                       res,
	input  wire logic                  cfg_write_en,
	input  wire logic                  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	logic [2:0] mirroring_q;
	logic       video_block_q;
	logic       take;
	logic       res_valid_q;
	res_t       res_q, res_next;

	// hold the input while the result register is full and not being taken
	assign cmd_stall = res_valid_q && res_stall;
	assign take      = cmd_valid && !cmd_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mirroring_q   <= MIR_HORIZONTAL;
			video_block_q <= 1'b0;
		end else if (cfg_write_en) begin
			unique case (cfg_index)
				CFG_MIRRORING:   mirroring_q   <= cfg_data;
				CFG_VIDEO_BLOCK: video_block_q <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	prsu_regfile u_regfile (
		.clk               (clk),
		.arst_n            (arst_n),
		.take              (take),
		.cmd               (cmd),
		.mirroring_mode    (mirroring_q),
		.video_write_block (video_block_q),
		.res               (res_next)
	);

	// result stage: load on every transfer in, drop valid once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (take) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			res_q <= res_next;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

`default_nettype wire
